// ----- src/request_stats_latency_histogram_unit_macros.svh -----
// Assertion macros used by the port-level checker of the request statistics unit.
// Depends on nothing; include by bare file name.
`ifndef REQUEST_STATS_LATENCY_HISTOGRAM_UNIT_MACROS_SVH
`define REQUEST_STATS_LATENCY_HISTOGRAM_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RSLH_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RSLH_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/rslh_pkg.sv -----
// Shared types, codes and the histogram bound table of the request statistics unit.
// Depends on nothing.
package rslh_pkg;

	localparam int DEFAULT_BUCKET_COUNT = 16;
	localparam int DEFAULT_COUNTER_BITS = 64;
	localparam int BOUND_TABLE_LEN      = 15;

	// Event operation codes.
	typedef enum logic [2:0] {
		OP_REQ_DONE     = 3'd0,
		OP_CONN_OPEN    = 3'd1,
		OP_CONN_CLOSE   = 3'd2,
		OP_UPSTREAM_ERR = 3'd3,
		OP_LATENCY      = 3'd4,
		OP_READ         = 3'd5
	} op_t;

	// Counter select codes for a read.
	localparam logic [4:0] SEL_TOTAL    = 5'd0;
	localparam logic [4:0] SEL_2XX      = 5'd1;
	localparam logic [4:0] SEL_4XX      = 5'd2;
	localparam logic [4:0] SEL_5XX      = 5'd3;
	localparam logic [4:0] SEL_ACTIVE   = 5'd4;
	localparam logic [4:0] SEL_UPSTREAM = 5'd5;
	localparam logic [4:0] SEL_SUM      = 5'd6;
	localparam logic [4:0] SEL_COUNT    = 5'd7;
	localparam logic [4:0] SEL_BIN_BASE = 5'd8;

	typedef struct packed {
		logic [2:0]  operation;
		logic [9:0]  status_code;
		logic [63:0] latency_sample;
		logic [4:0]  read_select;
	} event_t;

	typedef struct packed {
		logic [63:0] read_value;
		logic [3:0]  bucket_hit;
	} result_t;

	// Controller states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOK,
		ST_UPDATE,
		ST_HOLD
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic look;
		logic update;
	} ctrl_cmd_t;

	// Inclusive upper bounds of the histogram bins, in microseconds.
	localparam logic [63:0] BIN_LIMIT [BOUND_TABLE_LEN] = '{
		64'd100, 64'd500, 64'd1000, 64'd2000, 64'd5000, 64'd10000, 64'd20000,
		64'd50000, 64'd100000, 64'd200000, 64'd500000, 64'd1000000, 64'd2000000,
		64'd5000000, 64'd10000000
	};

	// True when a sample falls within the bound of bin idx; bins past the table never match.
	function automatic logic bin_fits(logic [63:0] sample, int idx);
		logic fits;
		fits = 1'b0;
		if (idx < BOUND_TABLE_LEN) begin
			fits = (sample <= BIN_LIMIT[idx[3:0]]);
		end
		return fits;
	endfunction

endpackage

// ----- src/rslh_if.sv -----
// Valid/ready channel interfaces for the event input and the result output.
// Depends on rslh_pkg for the payload types.
interface rslh_event_if import rslh_pkg::*; ();
	logic   valid;
	logic   ready;
	event_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface rslh_result_if import rslh_pkg::*; ();
	logic    valid;
	logic    ready;
	result_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ----- src/rslh_ctrl.sv -----
// Controller state machine that sequences one event through lookup, update and output.
// Depends on rslh_pkg for the state and command types.
module rslh_ctrl import rslh_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	output ctrl_cmd_t cmd
);

	state_t state_q;
	state_t state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and command decode.
	always_comb begin
		state_d     = state_q;
		in_ready    = 1'b0;
		out_valid   = 1'b0;
		cmd         = '0;
		case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
				if (in_valid) begin
					state_d = ST_LOOK;
				end
			end
			ST_LOOK: begin
				cmd.look = 1'b1;
				state_d  = ST_UPDATE;
			end
			ST_UPDATE: begin
				cmd.update = 1'b1;
				state_d    = ST_HOLD;
			end
			ST_HOLD: begin
				out_valid = 1'b1;
				if (out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ----- src/rslh_datapath.sv -----
// Datapath: event capture, bin selection, counters, the bin memory and the result register.
// Depends on rslh_pkg for types, codes and the bound table.
module rslh_datapath import rslh_pkg::*; #(
	parameter int BUCKET_COUNT = DEFAULT_BUCKET_COUNT,
	parameter int COUNTER_BITS = DEFAULT_COUNTER_BITS
) (
	input  logic      clk,
	input  logic      arst_n,
	input  ctrl_cmd_t cmd,
	input  event_t    event_data,
	output result_t   result_data
);

	localparam int BIN_W = $clog2(BUCKET_COUNT);

	// Captured event fields.
	logic [2:0]  op_q;
	logic [9:0]  status_q;
	logic [63:0] sample_q;
	logic [4:0]  sel_q;

	// Lookup results.
	logic [BIN_W-1:0] bin_idx;
	logic [BIN_W-1:0] bin_q;
	logic [5:0]       sel_off;
	logic             sel_in_bins;
	logic             sel_bin_q;
	logic [BIN_W-1:0] rd_addr;

	// Bin memory with one valid bit per entry.
	logic [COUNTER_BITS-1:0] bin_mem [BUCKET_COUNT];
	logic [BUCKET_COUNT-1:0] bin_vld_q;
	logic [COUNTER_BITS-1:0] rd_data_q;
	logic                    rd_vld_q;
	logic [COUNTER_BITS-1:0] bin_cnt;

	// Scalar counters.
	logic [COUNTER_BITS-1:0] total_q;
	logic [COUNTER_BITS-1:0] cnt_2xx_q;
	logic [COUNTER_BITS-1:0] cnt_4xx_q;
	logic [COUNTER_BITS-1:0] cnt_5xx_q;
	logic [COUNTER_BITS-1:0] active_q;
	logic [COUNTER_BITS-1:0] upstream_q;
	logic [COUNTER_BITS-1:0] lat_sum_q;
	logic [COUNTER_BITS-1:0] samples_q;

	logic [COUNTER_BITS-1:0] sel_value;
	logic [4:0]              bin_ext;
	result_t                 result_q;

	// Capture the event on transfer.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q     <= event_data.operation;
			status_q <= event_data.status_code;
			sample_q <= event_data.latency_sample;
			sel_q    <= event_data.read_select;
		end
	end

	// First bin whose bound the sample does not exceed; the last bin takes the rest.
	always_comb begin
		bin_idx = BIN_W'(BUCKET_COUNT - 1);
		for (int i = BUCKET_COUNT - 2; i >= 0; i--) begin
			if (bin_fits(sample_q, i)) begin
				bin_idx = BIN_W'(i);
			end
		end
	end

	// Bin offset of a read select, and whether it names a bin at all.
	assign sel_off     = {1'b0, sel_q} - {1'b0, SEL_BIN_BASE};
	assign sel_in_bins = (sel_q >= SEL_BIN_BASE) && (sel_off < 6'(BUCKET_COUNT));
	assign rd_addr     = (op_q == OP_READ) ? sel_off[BIN_W-1:0] : bin_idx;

	// Lookup step: register the bin and read the memory.
	always_ff @(posedge clk) begin
		if (cmd.look) begin
			bin_q     <= bin_idx;
			sel_bin_q <= sel_in_bins;
			rd_data_q <= bin_mem[rd_addr];
			rd_vld_q  <= bin_vld_q[rd_addr];
		end
	end

	// An entry never written reads as zero.
	assign bin_cnt = rd_vld_q ? rd_data_q : '0;

	// Memory write of the incremented bin.
	always_ff @(posedge clk) begin
		if (cmd.update && (op_q == OP_LATENCY)) begin
			bin_mem[bin_q] <= bin_cnt + COUNTER_BITS'(1);
		end
	end

	// Valid bits, cleared at reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_vld_q <= '0;
		end else if (cmd.update && (op_q == OP_LATENCY)) begin
			bin_vld_q[bin_q] <= 1'b1;
		end
	end

	// Scalar counter updates; all wrap at the counter width.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q    <= '0;
			cnt_2xx_q  <= '0;
			cnt_4xx_q  <= '0;
			cnt_5xx_q  <= '0;
			active_q   <= '0;
			upstream_q <= '0;
			lat_sum_q  <= '0;
			samples_q  <= '0;
		end else if (cmd.update) begin
			case (op_q)
				OP_REQ_DONE: begin
					total_q <= total_q + COUNTER_BITS'(1);
					if (status_q inside {[10'd200:10'd299]}) begin
						cnt_2xx_q <= cnt_2xx_q + COUNTER_BITS'(1);
					end else if (status_q inside {[10'd400:10'd499]}) begin
						cnt_4xx_q <= cnt_4xx_q + COUNTER_BITS'(1);
					end else if (status_q >= 10'd500) begin
						cnt_5xx_q <= cnt_5xx_q + COUNTER_BITS'(1);
					end
				end
				OP_CONN_OPEN: begin
					active_q <= active_q + COUNTER_BITS'(1);
				end
				OP_CONN_CLOSE: begin
					active_q <= active_q - COUNTER_BITS'(1);
				end
				OP_UPSTREAM_ERR: begin
					upstream_q <= upstream_q + COUNTER_BITS'(1);
				end
				OP_LATENCY: begin
					lat_sum_q <= lat_sum_q + sample_q[COUNTER_BITS-1:0];
					samples_q <= samples_q + COUNTER_BITS'(1);
				end
				default: begin
				end
			endcase
		end
	end

	// Counter selected by a read.
	always_comb begin
		case (sel_q)
			SEL_TOTAL:    sel_value = total_q;
			SEL_2XX:      sel_value = cnt_2xx_q;
			SEL_4XX:      sel_value = cnt_4xx_q;
			SEL_5XX:      sel_value = cnt_5xx_q;
			SEL_ACTIVE:   sel_value = active_q;
			SEL_UPSTREAM: sel_value = upstream_q;
			SEL_SUM:      sel_value = lat_sum_q;
			SEL_COUNT:    sel_value = samples_q;
			default:      sel_value = sel_bin_q ? bin_cnt : '0;
		endcase
	end

	assign bin_ext = 5'(bin_q);

	// Result register, loaded in the update step.
	always_ff @(posedge clk) begin
		if (cmd.update) begin
			result_q.read_value <= (op_q == OP_READ) ? 64'(sel_value) : 64'd0;
			result_q.bucket_hit <= (op_q == OP_LATENCY) ? bin_ext[3:0] : 4'd0;
		end
	end

	assign result_data = result_q;

endmodule

// ----- src/request_stats_latency_histogram_unit.sv -----
// Top level of the request statistics unit with latency histogram.
// Depends on rslh_pkg, rslh_if, rslh_ctrl and rslh_datapath.

// Each event passes from its input transfer to the result being offered in steps:
// the transfer, a bin lookup that reads the bin memory, an update that writes
// the counters, the bin memory and the result register, and the hold state that
// offers the result. The next event is taken in the cycle after the result
// transfer, so only one event is in flight and a stalling consumer holds off the
// next one. The bin memory has one read and one write port, and the read-then-write
// of a bin sets the lookup and update steps. All counters start at zero after
// reset and wrap at COUNTER_BITS; no clearing pass is needed.
module request_stats_latency_histogram_unit import rslh_pkg::*; #(
	parameter int BUCKET_COUNT = DEFAULT_BUCKET_COUNT,
	parameter int COUNTER_BITS = DEFAULT_COUNTER_BITS
) (
	input logic          clk,
	input logic          arst_n,
	rslh_event_if.sink   event_in,
	rslh_result_if.source result_out
);

	ctrl_cmd_t cmd;
	logic      in_ready;
	logic      out_valid;
	result_t   result_data;

	// Sequencing of one event at a time.
	rslh_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (event_in.valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (result_out.ready),
		.cmd       (cmd)
	);

	// Counters, bin memory and result register.
	rslh_datapath #(
		.BUCKET_COUNT (BUCKET_COUNT),
		.COUNTER_BITS (COUNTER_BITS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.event_data  (event_in.payload),
		.result_data (result_data)
	);

	// Channel handshakes.
	assign event_in.ready     = in_ready;
	assign result_out.valid   = out_valid;
	assign result_out.payload = result_data;

endmodule

// ----- src/rslh_checker.sv -----
// Port-level checker for the request statistics unit, bound to the top level.
// Depends on rslh_pkg and the assertion macro header.
`include "request_stats_latency_histogram_unit_macros.svh"

module rslh_checker import rslh_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    in_valid,
	input logic    in_ready,
	input logic    out_valid,
	input logic    out_ready,
	input result_t out_payload
);

	// A waiting result stays offered and unchanged until its transfer.
	`RSLH_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid, "result dropped")
	`RSLH_ASSERT_NEXT(a_out_stable, clk, arst_n, out_valid && !out_ready, $stable(out_payload), "result changed while stalled")

	// Only one event is in flight: no new input while a result is offered.
	`RSLH_ASSERT_NOW(a_one_in_flight, clk, arst_n, out_valid, !in_ready, "input taken while result pending")

	// An accepted event is never answered in the next cycle, and blocks further input.
	`RSLH_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && in_ready, !in_ready && !out_valid, "bad sequencing after transfer")

	// A latency result never carries a read value.
	`RSLH_ASSERT_NOW(a_hit_no_value, clk, arst_n, out_valid && (out_payload.bucket_hit != 4'd0), out_payload.read_value == 64'd0, "bucket hit with read value")

endmodule

bind request_stats_latency_histogram_unit rslh_checker u_rslh_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (event_in.valid),
	.in_ready    (event_in.ready),
	.out_valid   (result_out.valid),
	.out_ready   (result_out.ready),
	.out_payload (result_out.payload)
);

// ----- test/rslh_checker.sv -----
// Scoreboard for the request statistics unit: watches both channels, keeps its own
// copy of every counter and compares each result transfer with the predicted one.
// Depends on rslh_pkg for the event and result types, operation and select codes.
module rslh_scoreboard import rslh_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    ev_valid,
	input  logic    ev_ready,
	input  event_t  ev_payload,
	input  logic    res_valid,
	input  logic    res_ready,
	input  result_t res_payload,
	output int      mismatch_count,
	output int      outstanding
);

	localparam int BIN_TOTAL  = 16;
	localparam int BOUND_LEN  = 15;

	// Status class limits.
	localparam logic [9:0] STATUS_2XX_LO = 10'd200;
	localparam logic [9:0] STATUS_2XX_HI = 10'd299;
	localparam logic [9:0] STATUS_4XX_LO = 10'd400;
	localparam logic [9:0] STATUS_4XX_HI = 10'd499;
	localparam logic [9:0] STATUS_5XX_LO = 10'd500;

	// Inclusive upper bound of each latency bin; the last bin has no bound.
	localparam logic [63:0] LATENCY_BOUND [BOUND_LEN] = '{
		64'd100, 64'd500, 64'd1000, 64'd2000, 64'd5000, 64'd10000, 64'd20000,
		64'd50000, 64'd100000, 64'd200000, 64'd500000, 64'd1000000, 64'd2000000,
		64'd5000000, 64'd10000000
	};

	logic [63:0] req_total;
	logic [63:0] class_2xx;
	logic [63:0] class_4xx;
	logic [63:0] class_5xx;
	logic [63:0] conn_gauge;
	logic [63:0] upstream_errs;
	logic [63:0] latency_sum;
	logic [63:0] latency_samples;
	logic [63:0] bin_counts [BIN_TOTAL];
	result_t     expected_results [$];

	// First bin whose bound the sample does not exceed.
	function automatic logic [3:0] choose_bin(logic [63:0] sample);
		int i;
		for (i = 0; i < BOUND_LEN; i++) begin
			if (sample <= LATENCY_BOUND[i]) begin
				return i[3:0];
			end
		end
		return 4'(BIN_TOTAL - 1);
	endfunction

	// Applies one event to the shadow counters and returns the result it produces.
	function automatic result_t apply_event(event_t ev);
		result_t     r;
		logic [3:0]  bin;
		logic [4:0]  sel;
		r = '0;
		sel = ev.read_select;
		case (ev.operation)
			OP_REQ_DONE: begin
				req_total = req_total + 64'd1;
				if (ev.status_code >= STATUS_2XX_LO && ev.status_code <= STATUS_2XX_HI) begin
					class_2xx = class_2xx + 64'd1;
				end else if (ev.status_code >= STATUS_4XX_LO
						&& ev.status_code <= STATUS_4XX_HI) begin
					class_4xx = class_4xx + 64'd1;
				end else if (ev.status_code >= STATUS_5XX_LO) begin
					class_5xx = class_5xx + 64'd1;
				end
			end
			OP_CONN_OPEN: begin
				conn_gauge = conn_gauge + 64'd1;
			end
			OP_CONN_CLOSE: begin
				conn_gauge = conn_gauge - 64'd1;
			end
			OP_UPSTREAM_ERR: begin
				upstream_errs = upstream_errs + 64'd1;
			end
			OP_LATENCY: begin
				bin = choose_bin(ev.latency_sample);
				latency_sum = latency_sum + ev.latency_sample;
				latency_samples = latency_samples + 64'd1;
				bin_counts[bin] = bin_counts[bin] + 64'd1;
				r.bucket_hit = bin;
			end
			OP_READ: begin
				case (sel)
					SEL_TOTAL:    r.read_value = req_total;
					SEL_2XX:      r.read_value = class_2xx;
					SEL_4XX:      r.read_value = class_4xx;
					SEL_5XX:      r.read_value = class_5xx;
					SEL_ACTIVE:   r.read_value = conn_gauge;
					SEL_UPSTREAM: r.read_value = upstream_errs;
					SEL_SUM:      r.read_value = latency_sum;
					SEL_COUNT:    r.read_value = latency_samples;
					default: begin
						// Bin reads; selectors past the last bin read as zero.
						if (sel >= SEL_BIN_BASE && int'(sel - SEL_BIN_BASE) < BIN_TOTAL) begin
							r.read_value = bin_counts[4'(sel - SEL_BIN_BASE)];
						end
					end
				endcase
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	// Predict on each event transfer, compare on each result transfer.
	always @(posedge clk or negedge arst_n) begin
		result_t exp_res;
		if (!arst_n) begin
			req_total = '0;
			class_2xx = '0;
			class_4xx = '0;
			class_5xx = '0;
			conn_gauge = '0;
			upstream_errs = '0;
			latency_sum = '0;
			latency_samples = '0;
			for (int i = 0; i < BIN_TOTAL; i++) begin
				bin_counts[i] = '0;
			end
			expected_results.delete();
			mismatch_count = 0;
			outstanding = 0;
		end else begin
			if (res_valid && res_ready) begin
				if (expected_results.size() == 0) begin
					$error("result transfer with no event outstanding");
					mismatch_count++;
				end else begin
					exp_res = expected_results.pop_front();
					if (res_payload.read_value !== exp_res.read_value) begin
						$error("read_value: expected %h, actual %h",
							exp_res.read_value, res_payload.read_value);
						mismatch_count++;
					end
					if (res_payload.bucket_hit !== exp_res.bucket_hit) begin
						$error("bucket_hit: expected %0d, actual %0d",
							exp_res.bucket_hit, res_payload.bucket_hit);
						mismatch_count++;
					end
				end
			end
			if (ev_valid && ev_ready) begin
				expected_results.push_back(apply_event(ev_payload));
			end
			outstanding = expected_results.size();
		end
	end

endmodule

// ----- test/tb.sv -----
// Top of the request statistics unit testbench: clock, reset, event stimulus and
// result-side back-pressure, with the verdict taken from the checker.
// Depends on rslh_pkg, rslh_if, the unit itself and rslh_scoreboard.
module tb;
	import rslh_pkg::*;

	localparam int          CYCLE_LIMIT      = 200000;
	localparam int          RANDOM_PER_PHASE = 575;
	localparam int          LONG_HOLD        = 300;
	localparam int          DRAIN_CYCLES     = 12;
	localparam logic [2:0]  OP_SPARE_6       = 3'd6;
	localparam logic [2:0]  OP_SPARE_7       = 3'd7;

	logic clk;
	logic arst_n;
	int   cycle_count = 0;
	int   send_idle_pct = 21;
	int   recv_idle_pct = 48;
	bit   hold_pending = 1'b0;
	int   mismatch_count;
	int   outstanding;

	rslh_event_if  ev_if ();
	rslh_result_if res_if ();

	request_stats_latency_histogram_unit uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.event_in   (ev_if),
		.result_out (res_if)
	);

	rslh_scoreboard checker_i (
		.clk            (clk),
		.arst_n         (arst_n),
		.ev_valid       (ev_if.valid),
		.ev_ready       (ev_if.ready),
		.ev_payload     (ev_if.payload),
		.res_valid      (res_if.valid),
		.res_ready      (res_if.ready),
		.res_payload    (res_if.payload),
		.mismatch_count (mismatch_count),
		.outstanding    (outstanding)
	);

	// Clock with a period of 12.
	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// Run limit.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// Result-side ready: random stalls, plus a long hold-off when one is requested.
	initial begin
		res_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_pending) begin
				hold_pending = 1'b0;
				res_if.ready <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
			end else begin
				res_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
			end
		end
	end

	// Builds an event from the given operation, status, sample and select fields.
	function automatic event_t compose_event(logic [2:0] op, logic [9:0] status,
			logic [63:0] sample, logic [4:0] sel);
		event_t ev;
		ev.operation = op;
		ev.status_code = status;
		ev.latency_sample = sample;
		ev.read_select = sel;
		return ev;
	endfunction

	function automatic event_t random_event();
		event_t ev;
		int     pick;
		int     idx;
		pick = $urandom_range(0, 99);
		ev = compose_event(OP_READ, 10'($urandom), {$urandom, $urandom}, 5'($urandom));
		if (pick < 25) begin
			ev.operation = OP_REQ_DONE;
			// Bias status codes toward the class edges.
			case ($urandom_range(0, 3))
				0: ev.status_code = 10'($urandom);
				1: begin
					idx = $urandom_range(0, 9);
					case (idx)
						0: ev.status_code = 10'd199;
						1: ev.status_code = 10'd200;
						2: ev.status_code = 10'd299;
						3: ev.status_code = 10'd300;
						4: ev.status_code = 10'd399;
						5: ev.status_code = 10'd400;
						6: ev.status_code = 10'd499;
						7: ev.status_code = 10'd500;
						8: ev.status_code = 10'd1023;
						default: ev.status_code = 10'd0;
					endcase
				end
				2: ev.status_code = 10'($urandom_range(200, 299));
				default: ev.status_code = 10'($urandom_range(400, 599));
			endcase
		end else if (pick < 33) begin
			ev.operation = OP_CONN_OPEN;
		end else if (pick < 41) begin
			ev.operation = OP_CONN_CLOSE;
		end else if (pick < 46) begin
			ev.operation = OP_UPSTREAM_ERR;
		end else if (pick < 66) begin
			ev.operation = OP_LATENCY;
			// Half of the samples near a bin bound, the rest anywhere or small.
			case ($urandom_range(0, 5))
				0: ev.latency_sample = {$urandom, $urandom};
				1, 2, 3: begin
					idx = $urandom_range(0, BOUND_TABLE_LEN - 1);
					ev.latency_sample = BIN_LIMIT[idx] - 64'd1 + 64'($urandom_range(0, 2));
				end
				4: ev.latency_sample = 64'($urandom_range(0, 12000000));
				default: ev.latency_sample = 64'($urandom_range(0, 200));
			endcase
		end else if (pick < 96) begin
			ev.operation = OP_READ;
			if ($urandom_range(0, 99) < 85) begin
				ev.read_select = 5'($urandom_range(0, 23));
			end else begin
				ev.read_select = 5'($urandom_range(24, 31));
			end
		end else begin
			ev.operation = pick[0] ? OP_SPARE_7 : OP_SPARE_6;
		end
		return ev;
	endfunction

	// Offers one event from a falling edge and returns at the falling edge after its transfer.
	task automatic send_event(input event_t ev);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			ev_if.valid <= 1'b0;
			@(negedge clk);
		end
		ev_if.valid <= 1'b1;
		ev_if.payload <= ev;
		@(posedge clk);
		while (!ev_if.ready) @(posedge clk);
		@(negedge clk);
	endtask

	initial begin
		int phase;
		int n;
		ev_if.valid = 1'b0;
		ev_if.payload = '0;
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: reads at reset, gauge wrap, status class edges, bin edges,
		// widest sample, spare operations, an out-of-range selector and the last bin selector.
		send_event(compose_event(OP_READ, 10'd0, 64'd0, SEL_TOTAL));
		send_event(compose_event(OP_CONN_CLOSE, 10'd0, 64'd0, 5'd0));
		send_event(compose_event(OP_READ, 10'd0, 64'd0, SEL_ACTIVE));
		send_event(compose_event(OP_CONN_OPEN, 10'd0, 64'd0, 5'd0));
		send_event(compose_event(OP_REQ_DONE, 10'd200, 64'd0, 5'd0));
		send_event(compose_event(OP_REQ_DONE, 10'd299, 64'd0, 5'd0));
		send_event(compose_event(OP_REQ_DONE, 10'd199, 64'd0, 5'd0));
		send_event(compose_event(OP_REQ_DONE, 10'd300, 64'd0, 5'd0));
		send_event(compose_event(OP_REQ_DONE, 10'd399, 64'd0, 5'd0));
		send_event(compose_event(OP_REQ_DONE, 10'd400, 64'd0, 5'd0));
		send_event(compose_event(OP_REQ_DONE, 10'd499, 64'd0, 5'd0));
		send_event(compose_event(OP_REQ_DONE, 10'd500, 64'd0, 5'd0));
		send_event(compose_event(OP_REQ_DONE, 10'd1023, 64'd0, 5'd0));
		send_event(compose_event(OP_REQ_DONE, 10'd0, 64'd0, 5'd0));
		send_event(compose_event(OP_UPSTREAM_ERR, 10'd0, 64'd0, 5'd0));
		send_event(compose_event(OP_LATENCY, 10'd0, 64'd0, 5'd0));
		send_event(compose_event(OP_LATENCY, 10'd0, 64'd100, 5'd0));
		send_event(compose_event(OP_LATENCY, 10'd0, 64'd101, 5'd0));
		send_event(compose_event(OP_LATENCY, 10'd0, 64'd10000000, 5'd0));
		send_event(compose_event(OP_LATENCY, 10'd0, 64'd10000001, 5'd0));
		send_event(compose_event(OP_LATENCY, 10'd0, '1, 5'd0));
		send_event(compose_event(OP_SPARE_6, '1, '1, '1));
		send_event(compose_event(OP_SPARE_7, '1, '1, '1));
		send_event(compose_event(OP_READ, 10'd0, 64'd0, 5'd31));
		send_event(compose_event(OP_READ, 10'd0, 64'd0, 5'd23));

		// Random traffic in three idling phases, with a long result stall in two of them.
		for (phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 21;
					recv_idle_pct = 48;
				end
				1: begin
					send_idle_pct = 48;
					recv_idle_pct = 21;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			for (n = 0; n < RANDOM_PER_PHASE; n++) begin
				if (n == 100 && phase != 1) begin
					hold_pending = 1'b1;
				end
				send_event(random_event());
			end
		end
		ev_if.valid <= 1'b0;

		// Drain the remaining results.
		while (outstanding != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatch_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
